[rtl/core/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants, codes, types and the Clarke coefficient table for the
// Clarke / Park transform pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int DEF_SAMPLE_WIDTH   = 16;
	localparam int DEF_TRIG_FRAC_BITS = 14;
	localparam int INT_HEADROOM       = 4;
	localparam int KIND_WIDTH         = 3;
	localparam int COEF_FRAC          = 24;
	localparam int COEF_WIDTH         = COEF_FRAC + 2;

	localparam logic [KIND_WIDTH-1:0] KIND_CLARKE     = 3'd0;
	localparam logic [KIND_WIDTH-1:0] KIND_INV_CLARKE = 3'd1;
	localparam logic [KIND_WIDTH-1:0] KIND_PARK       = 3'd2;
	localparam logic [KIND_WIDTH-1:0] KIND_INV_PARK   = 3'd3;
	localparam logic [KIND_WIDTH-1:0] KIND_ABC_DQ0    = 3'd4;
	localparam logic [KIND_WIDTH-1:0] KIND_DQ0_ABC    = 3'd5;

	typedef struct packed {
		logic [KIND_WIDTH-1:0] kind;
		logic                  power_invariant;
	} cpt_ctrl_t;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;

	localparam int K_ONE  = 16777216;
	localparam int K_HALF = 8388608;
	localparam int K_2_3  = 11184811;
	localparam int K_1_3  = 5592405;
	localparam int K_R3   = 9686330;
	localparam int K_H3   = 14529495;
	localparam int K_S23  = 13698540;
	localparam int K_R6   = 6849270;
	localparam int K_R2   = 11863283;

	// rows of {inverse, power_invariant}, each a 3x3 matrix row by row
	localparam coef_t COEF_TABLE [4][9] = '{
		'{coef_t'(K_2_3), coef_t'(-K_1_3), coef_t'(-K_1_3),
		  coef_t'(0), coef_t'(K_R3), coef_t'(-K_R3),
		  coef_t'(K_1_3), coef_t'(K_1_3), coef_t'(K_1_3)},
		'{coef_t'(K_S23), coef_t'(-K_R6), coef_t'(-K_R6),
		  coef_t'(0), coef_t'(K_R2), coef_t'(-K_R2),
		  coef_t'(K_R3), coef_t'(K_R3), coef_t'(K_R3)},
		'{coef_t'(K_ONE), coef_t'(0), coef_t'(K_ONE),
		  coef_t'(-K_HALF), coef_t'(K_H3), coef_t'(K_ONE),
		  coef_t'(-K_HALF), coef_t'(-K_H3), coef_t'(K_ONE)},
		'{coef_t'(K_S23), coef_t'(0), coef_t'(K_R3),
		  coef_t'(-K_R6), coef_t'(K_R2), coef_t'(K_R3),
		  coef_t'(-K_R6), coef_t'(-K_R2), coef_t'(K_R3)}
	};

	function automatic logic kind_defined(input logic [KIND_WIDTH-1:0] kind);
		return kind <= KIND_DQ0_ABC;
	endfunction

endpackage

[rtl/core/cpt_if.sv]
// ----------------------------------------------------------------------------
// cpt channel interfaces
// Valid/ready channels for sample sets, results and the scaling register.
// ----------------------------------------------------------------------------
interface cpt_in_if #(
	parameter int SAMPLE_WIDTH = cpt_pkg::DEF_SAMPLE_WIDTH,
	parameter int TRIG_WIDTH   = cpt_pkg::DEF_TRIG_FRAC_BITS + 2
);
	import cpt_pkg::*;

	logic                           valid;
	logic                           ready;
	logic [KIND_WIDTH-1:0]          kind;
	logic signed [SAMPLE_WIDTH-1:0] in_first;
	logic signed [SAMPLE_WIDTH-1:0] in_second;
	logic signed [SAMPLE_WIDTH-1:0] in_third;
	logic signed [TRIG_WIDTH-1:0]   sine;
	logic signed [TRIG_WIDTH-1:0]   cosine;

	modport source (output valid, kind, in_first, in_second, in_third, sine, cosine,
		input ready);
	modport sink (input valid, kind, in_first, in_second, in_third, sine, cosine,
		output ready);
endinterface

interface cpt_out_if #(
	parameter int SAMPLE_WIDTH = cpt_pkg::DEF_SAMPLE_WIDTH
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_first;
	logic signed [SAMPLE_WIDTH-1:0] out_second;
	logic signed [SAMPLE_WIDTH-1:0] out_third;
	logic                           out_saturated;

	modport source (output valid, out_first, out_second, out_third, out_saturated,
		input ready);
	modport sink (input valid, out_first, out_second, out_third, out_saturated,
		output ready);
endinterface

interface cpt_cfg_if;
	logic valid;
	logic ready;
	logic power_invariant;

	modport source (output valid, power_invariant, input ready);
	modport sink (input valid, power_invariant, output ready);
endinterface

[rtl/core/clarke_park_transform.sv]
// ----------------------------------------------------------------------------
// clarke_park_transform
// Clarke, Park and combined abc/dq0 transforms on signed sample sets, with
// selectable amplitude- or power-invariant scaling and saturated results.
//
//   channel   modport  moves
//   samples   sink     kind, three samples, sine, cosine
//   results   source   three saturated samples, saturation flag
//   cfg       sink     power_invariant scaling bit
//
// one sample set per cycle sustained while results are taken; pipeline: input register,
// inverse rotation (2), Clarke matrix (2), forward rotation (2), output
// saturation register
// each stage holds its item under backpressure and empty stages fill, so
// samples.ready stays high while the output register is free
// reset empties the pipeline and selects amplitude-invariant scaling
// ----------------------------------------------------------------------------
module clarke_park_transform #(
	parameter int SAMPLE_WIDTH   = cpt_pkg::DEF_SAMPLE_WIDTH,
	parameter int TRIG_FRAC_BITS = cpt_pkg::DEF_TRIG_FRAC_BITS
) (
	input logic      clk,
	input logic      arst_n,
	cpt_in_if.sink   samples,
	cpt_out_if.source results,
	cpt_cfg_if.sink  cfg
);
	import cpt_pkg::*;

	localparam int IW = SAMPLE_WIDTH + INT_HEADROOM;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam logic signed [TW-1:0] TRIG_MAX = TW'(1) << TRIG_FRAC_BITS;
	localparam logic signed [TW-1:0] TRIG_MIN = -TRIG_MAX;
	localparam logic signed [IW-1:0] SMAX = {{(IW-SAMPLE_WIDTH+1){1'b0}},
		{(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [IW-1:0] SMIN = {{(IW-SAMPLE_WIDTH+1){1'b1}},
		{(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMAX_W = SMAX[SAMPLE_WIDTH-1:0];
	localparam logic signed [SAMPLE_WIDTH-1:0] SMIN_W = SMIN[SAMPLE_WIDTH-1:0];

	function automatic logic signed [TW-1:0] clamp_trig(input logic signed [TW-1:0] t);
		if (t > TRIG_MAX) begin
			return TRIG_MAX;
		end else if (t < TRIG_MIN) begin
			return TRIG_MIN;
		end
		return t;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] clip(input logic signed [IW-1:0] v);
		if (v > SMAX) begin
			return SMAX_W;
		end else if (v < SMIN) begin
			return SMIN_W;
		end
		return v[SAMPLE_WIDTH-1:0];
	endfunction

	function automatic logic over(input logic signed [IW-1:0] v);
		return (v > SMAX) || (v < SMIN);
	endfunction

	logic power_invariant_q;

	logic                 en_s1, v_s1;
	cpt_ctrl_t            ctrl_s1;
	logic signed [IW-1:0] x0_s1, x1_s1, x2_s1;
	logic signed [TW-1:0] sine_s1, cos_s1;

	logic                 ir_ready, ir_valid, mx_ready, mx_valid, fr_ready, fr_valid;
	cpt_ctrl_t            ir_ctrl, mx_ctrl, fr_ctrl;
	logic signed [IW-1:0] ir_x0, ir_x1, ir_x2, mx_x0, mx_x1, mx_x2, fr_x0, fr_x1, fr_x2;
	logic signed [TW-1:0] ir_sine, ir_cos, mx_sine, mx_cos, fr_sine, fr_cos;

	logic                           en_s8, v_s8, sat_s8;
	logic signed [SAMPLE_WIDTH-1:0] o0_s8, o1_s8, o2_s8;

	// scaling register; the user writes it only while idle, which the block itself does not enforce
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_invariant_q <= 1'b0;
		end else if (cfg.valid) begin
			power_invariant_q <= cfg.power_invariant;
		end
	end

	// input register
	assign en_s1         = !v_s1 || ir_ready;
	assign samples.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctrl_s1.kind            <= samples.kind;
			ctrl_s1.power_invariant <= power_invariant_q;
			x0_s1   <= {{(IW-SAMPLE_WIDTH){samples.in_first[SAMPLE_WIDTH-1]}},
				samples.in_first};
			x1_s1   <= {{(IW-SAMPLE_WIDTH){samples.in_second[SAMPLE_WIDTH-1]}},
				samples.in_second};
			x2_s1   <= {{(IW-SAMPLE_WIDTH){samples.in_third[SAMPLE_WIDTH-1]}},
				samples.in_third};
			sine_s1 <= clamp_trig(samples.sine);
			cos_s1  <= clamp_trig(samples.cosine);
		end
	end

	cpt_rotator #(.IW(IW), .TW(TW), .INVERSE(1'b1)) u_inv_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s1),
		.in_ready   (ir_ready),
		.in_ctrl    (ctrl_s1),
		.in_x0      (x0_s1),
		.in_x1      (x1_s1),
		.in_x2      (x2_s1),
		.in_sine    (sine_s1),
		.in_cosine  (cos_s1),
		.out_valid  (ir_valid),
		.out_ready  (mx_ready),
		.out_ctrl   (ir_ctrl),
		.out_x0     (ir_x0),
		.out_x1     (ir_x1),
		.out_x2     (ir_x2),
		.out_sine   (ir_sine),
		.out_cosine (ir_cos)
	);

	cpt_matrix #(.IW(IW), .TW(TW)) u_matrix (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (ir_valid),
		.in_ready   (mx_ready),
		.in_ctrl    (ir_ctrl),
		.in_x0      (ir_x0),
		.in_x1      (ir_x1),
		.in_x2      (ir_x2),
		.in_sine    (ir_sine),
		.in_cosine  (ir_cos),
		.out_valid  (mx_valid),
		.out_ready  (fr_ready),
		.out_ctrl   (mx_ctrl),
		.out_x0     (mx_x0),
		.out_x1     (mx_x1),
		.out_x2     (mx_x2),
		.out_sine   (mx_sine),
		.out_cosine (mx_cos)
	);

	cpt_rotator #(.IW(IW), .TW(TW), .INVERSE(1'b0)) u_fwd_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (mx_valid),
		.in_ready   (fr_ready),
		.in_ctrl    (mx_ctrl),
		.in_x0      (mx_x0),
		.in_x1      (mx_x1),
		.in_x2      (mx_x2),
		.in_sine    (mx_sine),
		.in_cosine  (mx_cos),
		.out_valid  (fr_valid),
		.out_ready  (en_s8),
		.out_ctrl   (fr_ctrl),
		.out_x0     (fr_x0),
		.out_x1     (fr_x1),
		.out_x2     (fr_x2),
		.out_sine   (fr_sine),
		.out_cosine (fr_cos)
	);

	// output register with saturation
	assign en_s8 = !v_s8 || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en_s8) begin
			v_s8 <= fr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			if (kind_defined(fr_ctrl.kind)) begin
				o0_s8  <= clip(fr_x0);
				o1_s8  <= clip(fr_x1);
				o2_s8  <= clip(fr_x2);
				sat_s8 <= over(fr_x0) || over(fr_x1) || over(fr_x2);
			end else begin
				o0_s8  <= '0;
				o1_s8  <= '0;
				o2_s8  <= '0;
				sat_s8 <= 1'b0;
			end
		end
	end

	assign results.valid         = v_s8;
	assign results.out_first     = o0_s8;
	assign results.out_second    = o1_s8;
	assign results.out_third     = o2_s8;
	assign results.out_saturated = sat_s8;

	// trig values only feed the rotations; the last copy ends here
	logic trig_tail_unused;
	assign trig_tail_unused = ^{fr_sine, fr_cos, fr_ctrl.power_invariant};

`ifndef SYNTHESIS
	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!results.valid |-> samples.ready)
		else $error("input stalled with an empty output register");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.out_saturated |->
		(results.out_first == SMAX_W) || (results.out_first == SMIN_W) ||
		(results.out_second == SMAX_W) || (results.out_second == SMIN_W) ||
		(results.out_third == SMAX_W) || (results.out_third == SMIN_W))
		else $error("saturation flag without a clipped result");

	a_input_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !ir_ready |=> v_s1 && $stable(ctrl_s1) && $stable(x0_s1))
		else $error("input stage lost its item under backpressure");

	a_fwd_rot_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !en_s8 |=> fr_valid && $stable(fr_x0) && $stable(fr_x1))
		else $error("rotation stage changed while stalled");
`endif

endmodule

[rtl/core/cpt_rotator.sv]
// ----------------------------------------------------------------------------
// cpt_rotator
// Two-stage Park rotation: registered products, then sum and round.
// Items of other kinds pass through unchanged.
// ----------------------------------------------------------------------------
module cpt_rotator #(
	parameter int IW      = 20,
	parameter int TW      = 16,
	parameter bit INVERSE = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cpt_pkg::cpt_ctrl_t  in_ctrl,
	input  logic signed [IW-1:0] in_x0,
	input  logic signed [IW-1:0] in_x1,
	input  logic signed [IW-1:0] in_x2,
	input  logic signed [TW-1:0] in_sine,
	input  logic signed [TW-1:0] in_cosine,
	output logic                out_valid,
	input  logic                out_ready,
	output cpt_pkg::cpt_ctrl_t  out_ctrl,
	output logic signed [IW-1:0] out_x0,
	output logic signed [IW-1:0] out_x1,
	output logic signed [IW-1:0] out_x2,
	output logic signed [TW-1:0] out_sine,
	output logic signed [TW-1:0] out_cosine
);
	import cpt_pkg::*;

	localparam int TF = TW - 2;
	localparam int PW = IW + TW;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] HALF = SW'(1) << (TF - 1);

	logic                 en_s1, en_s2, active;
	logic                 v_s1, v_s2, act_s1;
	cpt_ctrl_t            ctrl_s1, ctrl_s2;
	logic signed [IW-1:0] x0_s1, x1_s1, x2_s1;
	logic signed [TW-1:0] sine_s1, cos_s1, sine_s2, cos_s2;
	logic signed [PW-1:0] xc_s1, ys_s1, xs_s1, yc_s1;
	logic signed [IW-1:0] y0_s2, y1_s2, y2_s2;
	logic signed [SW-1:0] sum0, sum1, rnd0, rnd1;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		if (INVERSE) begin
			active = (in_ctrl.kind == KIND_INV_PARK) || (in_ctrl.kind == KIND_DQ0_ABC);
		end else begin
			active = (in_ctrl.kind == KIND_PARK) || (in_ctrl.kind == KIND_ABC_DQ0);
		end
	end

	// products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctrl_s1 <= in_ctrl;
			act_s1  <= active;
			x0_s1   <= in_x0;
			x1_s1   <= in_x1;
			x2_s1   <= in_x2;
			sine_s1 <= in_sine;
			cos_s1  <= in_cosine;
			xc_s1   <= in_x0 * in_cosine;
			ys_s1   <= in_x1 * in_sine;
			xs_s1   <= in_x0 * in_sine;
			yc_s1   <= in_x1 * in_cosine;
		end
	end

	// sums, round half up
	always_comb begin
		if (INVERSE) begin
			sum0 = SW'(xc_s1) - SW'(ys_s1);
			sum1 = SW'(xs_s1) + SW'(yc_s1);
		end else begin
			sum0 = SW'(xc_s1) + SW'(ys_s1);
			sum1 = SW'(yc_s1) - SW'(xs_s1);
		end
		rnd0 = sum0 + HALF;
		rnd1 = sum1 + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctrl_s2 <= ctrl_s1;
			sine_s2 <= sine_s1;
			cos_s2  <= cos_s1;
			y2_s2   <= x2_s1;
			if (act_s1) begin
				y0_s2 <= rnd0[TF+IW-1:TF];
				y1_s2 <= rnd1[TF+IW-1:TF];
			end else begin
				y0_s2 <= x0_s1;
				y1_s2 <= x1_s1;
			end
		end
	end

	assign out_valid  = v_s2;
	assign out_ctrl   = ctrl_s2;
	assign out_x0     = y0_s2;
	assign out_x1     = y1_s2;
	assign out_x2     = y2_s2;
	assign out_sine   = sine_s2;
	assign out_cosine = cos_s2;

endmodule

[rtl/core/cpt_matrix.sv]
// ----------------------------------------------------------------------------
// cpt_matrix
// Two-stage 3x3 Clarke matrix product: nine registered products, then row
// sums rounded to integer samples. Park-only kinds pass through.
// ----------------------------------------------------------------------------
module cpt_matrix #(
	parameter int IW = 20,
	parameter int TW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cpt_pkg::cpt_ctrl_t  in_ctrl,
	input  logic signed [IW-1:0] in_x0,
	input  logic signed [IW-1:0] in_x1,
	input  logic signed [IW-1:0] in_x2,
	input  logic signed [TW-1:0] in_sine,
	input  logic signed [TW-1:0] in_cosine,
	output logic                out_valid,
	input  logic                out_ready,
	output cpt_pkg::cpt_ctrl_t  out_ctrl,
	output logic signed [IW-1:0] out_x0,
	output logic signed [IW-1:0] out_x1,
	output logic signed [IW-1:0] out_x2,
	output logic signed [TW-1:0] out_sine,
	output logic signed [TW-1:0] out_cosine
);
	import cpt_pkg::*;

	localparam int PW = IW + COEF_WIDTH;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] HALF = SW'(1) << (COEF_FRAC - 1);

	logic                 en_s1, en_s2, fwd, active;
	logic [1:0]           sel;
	logic signed [IW-1:0] xin [3];
	logic                 v_s1, v_s2, act_s1;
	cpt_ctrl_t            ctrl_s1, ctrl_s2;
	logic signed [IW-1:0] x_s1 [3];
	logic signed [IW-1:0] y_s2 [3];
	logic signed [TW-1:0] sine_s1, cos_s1, sine_s2, cos_s2;
	logic signed [PW-1:0] prod_s1 [9];
	logic signed [SW-1:0] rnd [3];

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign fwd    = (in_ctrl.kind == KIND_CLARKE) || (in_ctrl.kind == KIND_ABC_DQ0);
	assign active = fwd || (in_ctrl.kind == KIND_INV_CLARKE) ||
		(in_ctrl.kind == KIND_DQ0_ABC);
	assign sel    = {~fwd, in_ctrl.power_invariant};
	assign xin[0] = in_x0;
	assign xin[1] = in_x1;
	assign xin[2] = in_x2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctrl_s1 <= in_ctrl;
			act_s1  <= active;
			sine_s1 <= in_sine;
			cos_s1  <= in_cosine;
			x_s1    <= xin;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			always_ff @(posedge clk) begin
				if (en_s1) begin
					prod_s1[i*3+j] <= xin[j] * COEF_TABLE[sel][i*3+j];
				end
			end
		end

		assign rnd[i] = SW'(prod_s1[i*3]) + SW'(prod_s1[i*3+1]) + SW'(prod_s1[i*3+2]) + HALF;

		always_ff @(posedge clk) begin
			if (en_s2) begin
				if (act_s1) begin
					y_s2[i] <= rnd[i][COEF_FRAC+IW-1:COEF_FRAC];
				end else begin
					y_s2[i] <= x_s1[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctrl_s2 <= ctrl_s1;
			sine_s2 <= sine_s1;
			cos_s2  <= cos_s1;
		end
	end

	assign out_valid  = v_s2;
	assign out_ctrl   = ctrl_s2;
	assign out_x0     = y_s2[0];
	assign out_x1     = y_s2[1];
	assign out_x2     = y_s2[2];
	assign out_sine   = sine_s2;
	assign out_cosine = cos_s2;

endmodule

[dv/clarke_park_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clarke_park_monitor
// Watches the sample, result and scaling channels of the Clarke / Park
// transform, works out the expected sample set for every accepted input and
// compares each result transfer field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module clarke_park_monitor (
	input  logic clk,
	input  logic arst_n,
	cpt_in_if    samples,
	cpt_out_if   results,
	cpt_cfg_if   cfg,
	output int   mismatches,
	output int   pending
);
	import cpt_pkg::*;

	localparam int SW = DEF_SAMPLE_WIDTH;
	localparam int TF = DEF_TRIG_FRAC_BITS;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam longint TRIG_ONE   = longint'(1) <<< TF;

	typedef struct packed {
		logic [SW-1:0] first;
		logic [SW-1:0] second;
		logic [SW-1:0] third;
		logic          saturated;
	} transform_result_t;

	// index {inverse, power_invariant}, each matrix row by row
	longint            clarke_coef [4][9];
	logic              power_invariant_q;
	transform_result_t expected_results [$];

	initial begin
		clarke_coef[0] = '{K_2_3, -K_1_3, -K_1_3, 0, K_R3, -K_R3, K_1_3, K_1_3, K_1_3};
		clarke_coef[1] = '{K_S23, -K_R6, -K_R6, 0, K_R2, -K_R2, K_R3, K_R3, K_R3};
		clarke_coef[2] = '{K_ONE, 0, K_ONE, -K_HALF, K_H3, K_ONE, -K_HALF, -K_H3, K_ONE};
		clarke_coef[3] = '{K_S23, 0, K_R3, -K_R6, K_R2, K_R3, -K_R6, -K_R2, K_R3};
	end

	// nearest, ties toward plus infinity
	function automatic longint round_half_up(input longint x, input int shift);
		return (x + (longint'(1) <<< (shift - 1))) >>> shift;
	endfunction

	function automatic longint clamp_trig(input logic signed [TF+1:0] raw);
		longint t;
		t = longint'(raw);
		if (t > TRIG_ONE)
			return TRIG_ONE;
		if (t < -TRIG_ONE)
			return -TRIG_ONE;
		return t;
	endfunction

	function automatic void clarke_product(input int sel, input longint x0, x1, x2,
		output longint y0, y1, y2);
		y0 = round_half_up(clarke_coef[sel][0] * x0 + clarke_coef[sel][1] * x1
			+ clarke_coef[sel][2] * x2, COEF_FRAC);
		y1 = round_half_up(clarke_coef[sel][3] * x0 + clarke_coef[sel][4] * x1
			+ clarke_coef[sel][5] * x2, COEF_FRAC);
		y2 = round_half_up(clarke_coef[sel][6] * x0 + clarke_coef[sel][7] * x1
			+ clarke_coef[sel][8] * x2, COEF_FRAC);
	endfunction

	function automatic void rotate(input longint x, y, sn, cs, input bit inverse,
		output longint o1, o2);
		if (!inverse) begin
			o1 = round_half_up(x * cs + y * sn, TF);
			o2 = round_half_up(y * cs - x * sn, TF);
		end else begin
			o1 = round_half_up(x * cs - y * sn, TF);
			o2 = round_half_up(x * sn + y * cs, TF);
		end
	endfunction

	function automatic logic [SW-1:0] clip_sample(input longint x, inout logic sat);
		if (x > SAMPLE_MAX) begin
			sat = 1'b1;
			return SW'(SAMPLE_MAX);
		end
		if (x < SAMPLE_MIN) begin
			sat = 1'b1;
			return SW'(SAMPLE_MIN);
		end
		return SW'(x);
	endfunction

	function automatic transform_result_t transform(input logic [KIND_WIDTH-1:0] kind,
		input logic signed [SW-1:0] a, b, c, input logic signed [TF+1:0] s_raw, c_raw,
		input logic pi);
		transform_result_t r;
		longint sn, cs, v0, v1, v2, t0, t1, t2, r0, r1, r2;
		logic sat;
		sn = clamp_trig(s_raw);
		cs = clamp_trig(c_raw);
		v0 = longint'(a);
		v1 = longint'(b);
		v2 = longint'(c);
		sat = 1'b0;
		r = '0;
		case (kind)
			KIND_CLARKE: clarke_product({1'b0, pi}, v0, v1, v2, r0, r1, r2);
			KIND_INV_CLARKE: clarke_product({1'b1, pi}, v0, v1, v2, r0, r1, r2);
			KIND_PARK: begin
				rotate(v0, v1, sn, cs, 1'b0, r0, r1);
				r2 = v2;
			end
			KIND_INV_PARK: begin
				rotate(v0, v1, sn, cs, 1'b1, r0, r1);
				r2 = v2;
			end
			KIND_ABC_DQ0: begin
				clarke_product({1'b0, pi}, v0, v1, v2, t0, t1, t2);
				rotate(t0, t1, sn, cs, 1'b0, r0, r1);
				r2 = t2;
			end
			KIND_DQ0_ABC: begin
				rotate(v0, v1, sn, cs, 1'b1, t0, t1);
				clarke_product({1'b1, pi}, t0, t1, v2, r0, r1, r2);
			end
			default: return r;
		endcase
		r.first = clip_sample(r0, sat);
		r.second = clip_sample(r1, sat);
		r.third = clip_sample(r2, sat);
		r.saturated = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string field, input logic [SW-1:0] got,
		input logic [SW-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", field, $signed(got),
				$signed(want)));
	endtask

	always @(posedge clk or negedge arst_n) begin
		transform_result_t want;
		if (!arst_n) begin
			power_invariant_q = 1'b0;
			expected_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with no sample set pending");
				end else begin
					want = expected_results.pop_front();
					compare_field("out_first", results.out_first, want.first);
					compare_field("out_second", results.out_second, want.second);
					compare_field("out_third", results.out_third, want.third);
					if (results.out_saturated !== want.saturated)
						report_mismatch($sformatf("out_saturated got %b expected %b",
							results.out_saturated, want.saturated));
				end
			end
			if (samples.valid && samples.ready)
				expected_results.push_back(transform(samples.kind, samples.in_first,
					samples.in_second, samples.in_third, samples.sine, samples.cosine,
					power_invariant_q));
			if (cfg.valid && cfg.ready)
				power_invariant_q = cfg.power_invariant;
			pending = expected_results.size();
		end
	end

endmodule

[dv/clarke_park_transform_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clarke_park_transform_tb
// Drives directed and random sample sets of every transform kind through the
// Clarke / Park block under both scaling settings, with random gaps on the
// sample side and random stalls on the result side; the monitor checks every
// result transfer.
// ----------------------------------------------------------------------------
module clarke_park_transform_tb;
	import cpt_pkg::*;

	localparam int SW = DEF_SAMPLE_WIDTH;
	localparam int TW = DEF_TRIG_FRAC_BITS + 2;
	localparam int TRIG_ONE = 1 << DEF_TRIG_FRAC_BITS;
	localparam int PIPE_DRAIN = 12;

	logic clk;
	logic arst_n;
	bit   calm;
	int   mismatches;
	int   pending;

	cpt_in_if  samples ();
	cpt_out_if results ();
	cpt_cfg_if cfg ();

	clarke_park_transform dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg)
	);

	clarke_park_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.results    (results),
		.cfg        (cfg),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("** clarke_park_transform: FAILED **");
		$finish;
	end

	task automatic send_sample_set(input logic [KIND_WIDTH-1:0] kind, input int a, b, c,
		input int sn, cs);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples.kind <= kind;
		samples.in_first <= SW'(a);
		samples.in_second <= SW'(b);
		samples.in_third <= SW'(c);
		samples.sine <= TW'(sn);
		samples.cosine <= TW'(cs);
		samples.valid <= 1'b1;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		samples.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	task automatic write_scaling(input logic power_invariant);
		wait_drained();
		cfg.power_invariant <= power_invariant;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic directed_sample_sets();
		send_sample_set(KIND_CLARKE, 0, 0, 0, 0, TRIG_ONE);
		send_sample_set(KIND_CLARKE, 32767, -32768, -32768, 0, TRIG_ONE);
		send_sample_set(KIND_INV_CLARKE, 32767, 32767, 32767, 0, TRIG_ONE);
		send_sample_set(KIND_INV_CLARKE, -32768, -32768, -32768, 0, TRIG_ONE);
		send_sample_set(KIND_PARK, 32767, 32767, -32768, TRIG_ONE, TRIG_ONE);
		send_sample_set(KIND_INV_PARK, -32768, -32768, 32767, -TRIG_ONE, TRIG_ONE);
		send_sample_set(KIND_ABC_DQ0, 32767, -32768, 0, 11585, 11585);
		send_sample_set(KIND_DQ0_ABC, -32768, 32767, 32767, -11585, -11585);
		// rounding ties, positive and negative
		send_sample_set(KIND_PARK, 1, 0, 5, 8192, 8192);
		send_sample_set(KIND_PARK, -1, 0, -5, 8192, 8192);
		// trig values beyond unity
		send_sample_set(KIND_PARK, 1000, -2000, 3, 32767, -32768);
		send_sample_set(KIND_INV_PARK, 12345, 23456, -7, TRIG_ONE + 1, -TRIG_ONE - 1);
		// undefined kinds
		send_sample_set(3'd6, 32767, 1, -1, 100, 200);
		send_sample_set(3'd7, -32768, -32768, -32768, -32768, -32768);
	endtask

	function automatic int random_sample();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1023) - 512;
			1: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	function automatic int random_trig();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 1) ? TRIG_ONE : -TRIG_ONE;
			default: return $urandom_range(0, 2 * TRIG_ONE) - TRIG_ONE;
		endcase
	endfunction

	task automatic random_sample_set();
		int pick;
		logic [KIND_WIDTH-1:0] kind;
		pick = $urandom_range(0, 19);
		kind = (pick < 18) ? KIND_WIDTH'(pick % 6) : KIND_WIDTH'(pick - 12);
		send_sample_set(kind, random_sample(), random_sample(), random_sample(),
			random_trig(), random_trig());
	endtask

	initial begin
		samples.valid = 1'b0;
		samples.kind = KIND_CLARKE;
		samples.in_first = '0;
		samples.in_second = '0;
		samples.in_third = '0;
		samples.sine = '0;
		samples.cosine = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.power_invariant = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_sample_sets();
		write_scaling(1'b1);
		directed_sample_sets();
		for (int phase = 0; phase < 4; phase++) begin
			write_scaling(phase[0]);
			for (int n = 0; n < 200; n++) begin
				if (n % 50 == 0)
					calm = ($urandom_range(0, 3) == 0);
				random_sample_set();
			end
		end
		wait_drained();

		if (mismatches == 0)
			$display("** clarke_park_transform: PASSED **");
		else
			$display("** clarke_park_transform: FAILED **");
		$finish;
	end

	// result side: random stalls before each transfer
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			results.ready <= 1'b1;
			@(posedge clk);
			while (!results.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

endmodule

[files.f]
rtl/core/cpt_pkg.sv
rtl/core/cpt_if.sv
rtl/core/cpt_rotator.sv
rtl/core/cpt_matrix.sv
rtl/core/clarke_park_transform.sv
dv/clarke_park_monitor.sv
dv/clarke_park_transform_tb.sv
